>>> rtl/maie_pkg.sv
// Shared types and constants of the MIPS ALU instruction executor.
// Holds instruction field codes, internal ALU op codes and the queue entry structs.
// Depends on nothing.
package maie_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned REG_AW   = 5;
   localparam int unsigned REG_NUM  = 32;
   localparam int unsigned SHAMT_W  = 5;
   localparam int unsigned OPCODE_W = 6;
   localparam int unsigned FUNCT_W  = 6;
   localparam int unsigned IMM_W    = 16;

   localparam int unsigned MID_QUEUE_DEPTH = 2;
   localparam int unsigned RSP_QUEUE_DEPTH = 2;

   localparam logic [DATA_W-1:0] PC_STEP = 32'd4;

   // primary opcodes
   localparam logic [OPCODE_W-1:0] OP_SPECIAL = 6'b000000;
   localparam logic [OPCODE_W-1:0] OP_ADDI    = 6'b001000;
   localparam logic [OPCODE_W-1:0] OP_ADDIU   = 6'b001001;
   localparam logic [OPCODE_W-1:0] OP_SLTI    = 6'b001010;
   localparam logic [OPCODE_W-1:0] OP_SLTIU   = 6'b001011;
   localparam logic [OPCODE_W-1:0] OP_ANDI    = 6'b001100;
   localparam logic [OPCODE_W-1:0] OP_ORI     = 6'b001101;
   localparam logic [OPCODE_W-1:0] OP_XORI    = 6'b001110;
   localparam logic [OPCODE_W-1:0] OP_LUI     = 6'b001111;

   // SPECIAL funct codes
   localparam logic [FUNCT_W-1:0] FN_SLL  = 6'b000000;
   localparam logic [FUNCT_W-1:0] FN_SRL  = 6'b000010;
   localparam logic [FUNCT_W-1:0] FN_SRA  = 6'b000011;
   localparam logic [FUNCT_W-1:0] FN_SLLV = 6'b000100;
   localparam logic [FUNCT_W-1:0] FN_SRLV = 6'b000110;
   localparam logic [FUNCT_W-1:0] FN_SRAV = 6'b000111;
   localparam logic [FUNCT_W-1:0] FN_ADD  = 6'b100000;
   localparam logic [FUNCT_W-1:0] FN_ADDU = 6'b100001;
   localparam logic [FUNCT_W-1:0] FN_SUB  = 6'b100010;
   localparam logic [FUNCT_W-1:0] FN_SUBU = 6'b100011;
   localparam logic [FUNCT_W-1:0] FN_AND  = 6'b100100;
   localparam logic [FUNCT_W-1:0] FN_OR   = 6'b100101;
   localparam logic [FUNCT_W-1:0] FN_XOR  = 6'b100110;
   localparam logic [FUNCT_W-1:0] FN_NOR  = 6'b100111;
   localparam logic [FUNCT_W-1:0] FN_SLT  = 6'b101010;
   localparam logic [FUNCT_W-1:0] FN_SLTU = 6'b101011;

   // internal ALU operations
   localparam int unsigned ALU_OP_W = 4;
   localparam logic [ALU_OP_W-1:0] ALU_ADD  = 4'd0;
   localparam logic [ALU_OP_W-1:0] ALU_SUB  = 4'd1;
   localparam logic [ALU_OP_W-1:0] ALU_AND  = 4'd2;
   localparam logic [ALU_OP_W-1:0] ALU_OR   = 4'd3;
   localparam logic [ALU_OP_W-1:0] ALU_XOR  = 4'd4;
   localparam logic [ALU_OP_W-1:0] ALU_NOR  = 4'd5;
   localparam logic [ALU_OP_W-1:0] ALU_SLT  = 4'd6;
   localparam logic [ALU_OP_W-1:0] ALU_SLTU = 4'd7;
   localparam logic [ALU_OP_W-1:0] ALU_SLL  = 4'd8;
   localparam logic [ALU_OP_W-1:0] ALU_SRL  = 4'd9;
   localparam logic [ALU_OP_W-1:0] ALU_SRA  = 4'd10;
   localparam logic [ALU_OP_W-1:0] ALU_PASS = 4'd11;

   // decoded instruction handed from front to back
   typedef struct packed {
      logic                known;
      logic                wr;        // known and destination is not r0
      logic [REG_AW-1:0]   dest;      // zero unless wr
      logic [REG_AW-1:0]   rs;
      logic [REG_AW-1:0]   rt;
      logic [ALU_OP_W-1:0] alu_op;
      logic                use_imm;
      logic                use_var;   // shift amount from rs
      logic [SHAMT_W-1:0]  shamt;
      logic [DATA_W-1:0]   imm;       // already extended or shifted
      logic [DATA_W-1:0]   next_pc;
   } uop_type;

   typedef struct packed {
      logic              status;
      logic              wrote;
      logic [REG_AW-1:0] dest_index;
      logic [DATA_W-1:0] write_value;
      logic [DATA_W-1:0] next_pc;
   } rsp_type;

endpackage

>>> rtl/maie_fifo.sv
// Small synchronous FIFO built from a register array.
// Used for the decoded-instruction queue and the result queue. No package use.
module maie_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> rtl/maie_front.sv
// Front end: accepts instruction words, decodes them and tracks the program counter.
// Uses maie_pkg for opcode/funct codes and the decoded instruction struct.
module maie_front
   import maie_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [DATA_W-1:0] req_instr_word,
   input  logic              q_full,
   output logic              q_push,
   output uop_type           q_data
);

   logic [DATA_W-1:0]   pc_ff, pc_in;
   logic [OPCODE_W-1:0] opcode;
   logic [FUNCT_W-1:0]  funct;
   logic [IMM_W-1:0]    imm16;
   logic [DATA_W-1:0]   simm, zimm;
   logic [REG_AW-1:0]   dest_raw;
   logic                known;

   assign opcode = req_instr_word[31:26];
   assign funct  = req_instr_word[5:0];
   assign imm16  = req_instr_word[15:0];
   assign simm   = {{(DATA_W - IMM_W){imm16[IMM_W-1]}}, imm16};
   assign zimm   = {{(DATA_W - IMM_W){1'b0}}, imm16};

   assign q_push = req_push && !q_full;
   assign pc_in  = q_push ? pc_ff + PC_STEP : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      q_data         = '0;
      known          = 1'b1;
      dest_raw       = req_instr_word[20:16];
      q_data.rs      = req_instr_word[25:21];
      q_data.rt      = req_instr_word[20:16];
      q_data.shamt   = req_instr_word[10:6];
      q_data.alu_op  = ALU_ADD;
      q_data.use_imm = 1'b1;
      q_data.use_var = 1'b0;
      q_data.imm     = simm;
      if (opcode == OP_SPECIAL) begin
         dest_raw       = req_instr_word[15:11];
         q_data.use_imm = 1'b0;
         case (funct)
            FN_SLL:          q_data.alu_op = ALU_SLL;
            FN_SRL:          q_data.alu_op = ALU_SRL;
            FN_SRA:          q_data.alu_op = ALU_SRA;
            FN_SLLV: begin
               q_data.alu_op  = ALU_SLL;
               q_data.use_var = 1'b1;
            end
            FN_SRLV: begin
               q_data.alu_op  = ALU_SRL;
               q_data.use_var = 1'b1;
            end
            FN_SRAV: begin
               q_data.alu_op  = ALU_SRA;
               q_data.use_var = 1'b1;
            end
            FN_ADD, FN_ADDU: q_data.alu_op = ALU_ADD;
            FN_SUB, FN_SUBU: q_data.alu_op = ALU_SUB;
            FN_AND:          q_data.alu_op = ALU_AND;
            FN_OR:           q_data.alu_op = ALU_OR;
            FN_XOR:          q_data.alu_op = ALU_XOR;
            FN_NOR:          q_data.alu_op = ALU_NOR;
            FN_SLT:          q_data.alu_op = ALU_SLT;
            FN_SLTU:         q_data.alu_op = ALU_SLTU;
            default:         known = 1'b0;
         endcase
      end else begin
         case (opcode)
            OP_ADDI, OP_ADDIU: q_data.alu_op = ALU_ADD;
            OP_SLTI:           q_data.alu_op = ALU_SLT;
            OP_SLTIU:          q_data.alu_op = ALU_SLTU;
            OP_ANDI: begin
               q_data.alu_op = ALU_AND;
               q_data.imm    = zimm;
            end
            OP_ORI: begin
               q_data.alu_op = ALU_OR;
               q_data.imm    = zimm;
            end
            OP_XORI: begin
               q_data.alu_op = ALU_XOR;
               q_data.imm    = zimm;
            end
            OP_LUI: begin
               q_data.alu_op = ALU_PASS;
               q_data.imm    = {imm16, {(DATA_W - IMM_W){1'b0}}};
            end
            default:           known = 1'b0;
         endcase
      end
      q_data.known   = known;
      q_data.wr      = known && (dest_raw != '0);
      q_data.dest    = q_data.wr ? dest_raw : '0;
      q_data.next_pc = pc_ff + PC_STEP;
   end

endmodule

>>> rtl/maie_back.sv
// Back end: register file read, ALU execute and register write-back.
// Uses maie_pkg for the decoded instruction and result structs and ALU op codes.
module maie_back
   import maie_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  uop_type q_data,
   output logic    q_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_data
);

   // register file: two registered read ports, one write port
   logic [DATA_W-1:0]  rf_mem_ff [REG_NUM];
   logic [REG_NUM-1:0] rf_vld_ff, rf_vld_in;

   logic              e_valid_ff, e_valid_in;
   uop_type           e_uop_ff;
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic              vld_a_ff, vld_b_ff;
   logic              byp_a_ff, byp_b_ff;
   logic [DATA_W-1:0] fwd_val_ff;

   logic              e_fire, r_load;
   logic [DATA_W-1:0] opa, opb, src2, alu_res, e_value;
   logic [SHAMT_W-1:0] sh;

   assign e_fire   = e_valid_ff && !out_full;
   assign r_load   = !q_empty && (!e_valid_ff || e_fire);
   assign q_pop    = r_load;
   assign out_push = e_fire;

   assign e_valid_in = r_load || (e_valid_ff && !e_fire);

   always_comb begin
      rf_vld_in = rf_vld_ff;
      if (e_fire && e_uop_ff.wr) begin
         rf_vld_in[e_uop_ff.dest] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         rf_vld_ff  <= '0;
      end else begin
         e_valid_ff <= e_valid_in;
         rf_vld_ff  <= rf_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_fire && e_uop_ff.wr) begin
         rf_mem_ff[e_uop_ff.dest] <= e_value;
      end
   end

   // read stage; the request leaving execute writes on this same edge, so catch it here
   always_ff @(posedge clock) begin
      if (r_load) begin
         e_uop_ff   <= q_data;
         rd_a_ff    <= rf_mem_ff[q_data.rs];
         rd_b_ff    <= rf_mem_ff[q_data.rt];
         vld_a_ff   <= rf_vld_ff[q_data.rs];
         vld_b_ff   <= rf_vld_ff[q_data.rt];
         byp_a_ff   <= e_fire && e_uop_ff.wr && (e_uop_ff.dest == q_data.rs);
         byp_b_ff   <= e_fire && e_uop_ff.wr && (e_uop_ff.dest == q_data.rt);
         fwd_val_ff <= e_value;
      end
   end

   assign opa  = byp_a_ff ? fwd_val_ff : (vld_a_ff ? rd_a_ff : '0);
   assign opb  = byp_b_ff ? fwd_val_ff : (vld_b_ff ? rd_b_ff : '0);
   assign src2 = e_uop_ff.use_imm ? e_uop_ff.imm : opb;
   assign sh   = e_uop_ff.use_var ? opa[SHAMT_W-1:0] : e_uop_ff.shamt;

   always_comb begin
      case (e_uop_ff.alu_op)
         ALU_ADD:  alu_res = opa + src2;
         ALU_SUB:  alu_res = opa - src2;
         ALU_AND:  alu_res = opa & src2;
         ALU_OR:   alu_res = opa | src2;
         ALU_XOR:  alu_res = opa ^ src2;
         ALU_NOR:  alu_res = ~(opa | src2);
         ALU_SLT:  alu_res = {{(DATA_W - 1){1'b0}}, ($signed(opa) < $signed(src2))};
         ALU_SLTU: alu_res = {{(DATA_W - 1){1'b0}}, (opa < src2)};
         ALU_SLL:  alu_res = opb << sh;
         ALU_SRL:  alu_res = opb >> sh;
         ALU_SRA:  alu_res = DATA_W'($signed(opb) >>> sh);
         ALU_PASS: alu_res = src2;
         default:  alu_res = '0;
      endcase
   end

   assign e_value = e_uop_ff.wr ? alu_res : '0;

   always_comb begin
      out_data.status      = !e_uop_ff.known;
      out_data.wrote       = e_uop_ff.wr;
      out_data.dest_index  = e_uop_ff.dest;
      out_data.write_value = e_value;
      out_data.next_pc     = e_uop_ff.next_pc;
   end

endmodule

>>> rtl/mips_alu_instruction_executor_top.sv
// MIPS ALU instruction executor: one result per instruction word.
// A request accepted at one edge moves through the decode queue, read and execute into
// the result queue. Throughput: one request per cycle while the result queue has room;
// the register file read/bypass and combinational ALU set that rate.
// Reset (synchronous): PC to zero, all registers read as zero, both queues empty.
// Uses maie_pkg, maie_front, maie_fifo and maie_back.
module mips_alu_instruction_executor_top
   import maie_pkg::*;
#(
   parameter int unsigned MID_DEPTH = MID_QUEUE_DEPTH,
   parameter int unsigned RSP_DEPTH = RSP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [DATA_W-1:0] req_instr_word,
   output logic              empty,
   input  logic              pop,
   output logic              rsp_status,
   output logic              rsp_wrote,
   output logic [REG_AW-1:0] rsp_dest_index,
   output logic [DATA_W-1:0] rsp_write_value,
   output logic [DATA_W-1:0] rsp_next_pc
);

   logic    mid_push, mid_full, mid_pop, mid_empty;
   uop_type mid_din, mid_dout;
   logic    rsp_push, rsp_full;
   rsp_type rsp_din, rsp_dout;

   maie_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (push),
      .req_instr_word (req_instr_word),
      .q_full         (mid_full),
      .q_push         (mid_push),
      .q_data         (mid_din)
   );

   maie_fifo #(
      .WIDTH ($bits(uop_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .din   (mid_din),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  (mid_dout),
      .empty (mid_empty)
   );

   maie_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (mid_empty),
      .q_data   (mid_dout),
      .q_pop    (mid_pop),
      .out_full (rsp_full),
      .out_push (rsp_push),
      .out_data (rsp_din)
   );

   maie_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_din),
      .full  (rsp_full),
      .pop   (pop),
      .dout  (rsp_dout),
      .empty (empty)
   );

   assign full            = mid_full;
   assign rsp_status      = rsp_dout.status;
   assign rsp_wrote       = rsp_dout.wrote;
   assign rsp_dest_index  = rsp_dout.dest_index;
   assign rsp_write_value = rsp_dout.write_value;
   assign rsp_next_pc     = rsp_dout.next_pc;

   a_wrote_nonzero_dest: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_wrote) |-> (rsp_dest_index != '0))
      else $error("write reported to register zero");

   a_unknown_no_write: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status) |-> (!rsp_wrote && rsp_write_value == '0))
      else $error("unknown instruction reported a write");

   a_no_write_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_wrote) |-> (rsp_dest_index == '0 && rsp_write_value == '0))
      else $error("non-writing result carries destination or value");

   a_back_waits_on_queue: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("back end popped an empty decode queue");

endmodule
